/* rtl/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register indexes and arithmetic helpers for the
// environment sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_TEMP    = 3'd0,
		CFG_PRESS_A = 3'd1,
		CFG_PRESS_B = 3'd2,
		CFG_PRESS_C = 3'd3,
		CFG_HUM     = 3'd4
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Output limits
	localparam logic signed [31:0] TEMP_LO  = -32'sd4000;
	localparam logic signed [31:0] TEMP_HI  = 32'sd8500;
	localparam logic [31:0]        PRESS_LO = 32'd30000;
	localparam logic [31:0]        PRESS_HI = 32'd110000;
	localparam logic signed [31:0] HUM_CAP  = 32'sd419430400;
	localparam logic [31:0]        HUM_HI   = 32'd102400;

	// Input beat: one raw data burst
	typedef struct packed {
		logic [7:0] press_msb;
		logic [7:0] press_lsb;
		logic [7:0] press_xlsb;
		logic [7:0] temp_msb;
		logic [7:0] temp_lsb;
		logic [7:0] temp_xlsb;
		logic [7:0] hum_msb;
		logic [7:0] hum_lsb;
	} in_beat_t;

	// Output beat: compensated values
	typedef struct packed {
		logic signed [14:0] temperature;
		logic [16:0]        pressure;
		logic [16:0]        humidity;
	} out_beat_t;

	// Calibration words
	typedef struct packed {
		logic [47:0] temp_calib;
		logic [63:0] press_calib_a;
		logic [63:0] press_calib_b;
		logic [15:0] press_calib_c;
		logic [63:0] hum_calib;
	} calib_t;

	// Front end to divider
	typedef struct packed {
		logic signed [14:0] temperature;
		logic [16:0]        humidity;
		logic               shifted;
		logic               zero;
		logic [31:0]        dividend;
		logic [31:0]        divisor;
	} front_t;

	// Divider to back end
	typedef struct packed {
		logic signed [14:0] temperature;
		logic [16:0]        humidity;
		logic               shifted;
		logic               zero;
		logic [31:0]        quotient;
	} quot_t;

	// Signed divide by 2**k, truncating toward zero
	function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
			input int unsigned k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

/* rtl/esc_front.sv */
// ----------------------------------------------------------------------------
// esc_front
// Fourteen-stage front end: raw unpack, fine temperature, temperature and
// humidity results, and the dividend and divisor of the pressure divide.
// ----------------------------------------------------------------------------
module esc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  esc_pkg::in_beat_t in_beat,
	input  esc_pkg::calib_t   calib,
	output logic          out_valid,
	output esc_pkg::front_t   out_data
);
	import esc_pkg::*;

	localparam int unsigned NSTAGE = 14;

	// Calibration fields
	logic signed [31:0] t1, t2, t3;
	logic signed [31:0] p1, p2, p3, p4, p5, p6;
	logic signed [31:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {16'd0, calib.temp_calib[15:0]};
	assign t2 = {{16{calib.temp_calib[31]}}, calib.temp_calib[31:16]};
	assign t3 = {{16{calib.temp_calib[47]}}, calib.temp_calib[47:32]};
	assign p1 = {16'd0, calib.press_calib_a[15:0]};
	assign p2 = {{16{calib.press_calib_a[31]}}, calib.press_calib_a[31:16]};
	assign p3 = {{16{calib.press_calib_a[47]}}, calib.press_calib_a[47:32]};
	assign p4 = {{16{calib.press_calib_a[63]}}, calib.press_calib_a[63:48]};
	assign p5 = {{16{calib.press_calib_b[15]}}, calib.press_calib_b[15:0]};
	assign p6 = {{16{calib.press_calib_b[31]}}, calib.press_calib_b[31:16]};
	assign h1 = {24'd0, calib.hum_calib[7:0]};
	assign h2 = {{16{calib.hum_calib[23]}}, calib.hum_calib[23:8]};
	assign h3 = {24'd0, calib.hum_calib[31:24]};
	assign h4 = {{20{calib.hum_calib[43]}}, calib.hum_calib[43:32]};
	assign h5 = {{20{calib.hum_calib[55]}}, calib.hum_calib[55:44]};
	assign h6 = {{24{calib.hum_calib[63]}}, calib.hum_calib[63:56]};

	// Valid bits travel with the data
	logic [NSTAGE-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[NSTAGE-1];

	// Stage 1: unpack raw values, temperature offsets
	logic [19:0] traw;
	logic [19:0] praw_s1;
	logic [15:0] hraw_s1;
	logic signed [31:0] ta_s1, tb_s1;

	assign traw = {in_beat.temp_msb, in_beat.temp_lsb, in_beat.temp_xlsb[7:4]};

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s1 <= {in_beat.press_msb, in_beat.press_lsb, in_beat.press_xlsb[7:4]};
			hraw_s1 <= {in_beat.hum_msb, in_beat.hum_lsb};
			ta_s1   <= $signed({15'd0, traw[19:3]}) - (t1 <<< 1);
			tb_s1   <= $signed({16'd0, traw[19:4]}) - t1;
		end
	end

	// Stage 2: temperature products
	logic [19:0] praw_s2;
	logic [15:0] hraw_s2;
	logic signed [31:0] tam_s2, tbb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s2 <= praw_s1;
			hraw_s2 <= hraw_s1;
			tam_s2  <= ta_s1 * t2;
			tbb_s2  <= tb_s1 * tb_s1;
		end
	end

	// Stage 3: scale, apply T3
	logic [19:0] praw_s3;
	logic [15:0] hraw_s3;
	logic signed [31:0] tad_s3, tb3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s3 <= praw_s2;
			hraw_s3 <= hraw_s2;
			tad_s3  <= sdiv_p2(tam_s2, 11);
			tb3_s3  <= sdiv_p2(tbb_s2, 12) * t3;
		end
	end

	// Stage 4: fine temperature
	logic [19:0] praw_s4;
	logic [15:0] hraw_s4;
	logic signed [31:0] fine_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s4 <= praw_s3;
			hraw_s4 <= hraw_s3;
			fine_s4 <= tad_s3 + sdiv_p2(tb3_s3, 14);
		end
	end

	// Stage 5: temperature result, pressure and humidity offsets
	logic signed [31:0] t5, tq, tcl;
	logic [19:0] praw_s5;
	logic [15:0] hraw_s5;
	logic signed [14:0] temp_s5;
	logic signed [31:0] pa_s5, ha_s5;

	always_comb begin
		t5 = (fine_s4 <<< 2) + fine_s4 + 32'sd128;
		tq = sdiv_p2(t5, 8);
		if (tq < TEMP_LO) begin
			tcl = TEMP_LO;
		end else if (tq > TEMP_HI) begin
			tcl = TEMP_HI;
		end else begin
			tcl = tq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s5 <= praw_s4;
			hraw_s5 <= hraw_s4;
			temp_s5 <= tcl[14:0];
			pa_s5   <= sdiv_p2(fine_s4, 1) - 32'sd64000;
			ha_s5   <= fine_s4 - 32'sd76800;
		end
	end

	// Stage 6: first products of both paths
	logic signed [31:0] q5;
	logic [19:0] praw_s6;
	logic signed [14:0] temp_s6;
	logic signed [31:0] qq_s6, ap5_s6, p2a_s6, hd5_s6, ah6_s6, ah3_s6, hb_s6;

	assign q5 = sdiv_p2(pa_s5, 2);

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s6 <= praw_s5;
			temp_s6 <= temp_s5;
			qq_s6   <= q5 * q5;
			ap5_s6  <= pa_s5 * p5;
			p2a_s6  <= p2 * pa_s5;
			hd5_s6  <= h5 * ha_s5;
			ah6_s6  <= ha_s5 * h6;
			ah3_s6  <= ha_s5 * h3;
			hb_s6   <= $signed({2'd0, hraw_s5, 14'd0});
		end
	end

	// Stage 7: second products, humidity base term
	logic [19:0] praw_s7;
	logic signed [14:0] temp_s7;
	logic signed [31:0] pb1_s7, pc_s7, pb2_s7, pd_s7, he_s7, hb6_s7, hc3_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s7 <= praw_s6;
			temp_s7 <= temp_s6;
			pb1_s7  <= sdiv_p2(qq_s6, 11) * p6;
			pc_s7   <= p3 * sdiv_p2(qq_s6, 13);
			pb2_s7  <= ap5_s6 <<< 1;
			pd_s7   <= sdiv_p2(p2a_s6, 1);
			he_s7   <= sdiv_p2(hb_s6 - (h4 <<< 20) - hd5_s6 + 32'sd16384, 15);
			hb6_s7  <= sdiv_p2(ah6_s6, 10);
			hc3_s7  <= sdiv_p2(ah3_s6, 11);
		end
	end

	// Stage 8: pressure offset and scale terms
	logic [19:0] praw_s8;
	logic signed [14:0] temp_s8;
	logic signed [31:0] bfin_s8, a2p_s8, hm_s8, he_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			praw_s8 <= praw_s7;
			temp_s8 <= temp_s7;
			bfin_s8 <= sdiv_p2(pb1_s7 + pb2_s7, 2) + (p4 <<< 16);
			a2p_s8  <= sdiv_p2(sdiv_p2(pc_s7, 3) + pd_s7, 18) + 32'sd32768;
			hm_s8   <= hb6_s7 * (hc3_s7 + 32'sd32768);
			he_s8   <= he_s7;
		end
	end

	// Stage 9: divisor product, raw pressure term
	logic [31:0] pdiff;
	logic signed [14:0] temp_s9;
	logic signed [31:0] a3m_s9, hd_s9, he_s9;
	logic [31:0] pr_s9;

	assign pdiff = (32'd1048576 - {12'd0, praw_s8}) - $unsigned(sdiv_p2(bfin_s8, 12));

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s9 <= temp_s8;
			a3m_s9  <= a2p_s8 * p1;
			pr_s9   <= pdiff * 32'd3125;
			hd_s9   <= sdiv_p2(hm_s8, 10) + 32'sd2097152;
			he_s9   <= he_s8;
		end
	end

	// Stage 10: dividend and divisor ready
	logic signed [31:0] dv9;
	front_t pf_s10;
	logic signed [31:0] hd2_s10, he_s10;

	assign dv9 = sdiv_p2(a3m_s9, 15);

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s10.temperature <= temp_s9;
			pf_s10.humidity    <= '0;
			pf_s10.shifted     <= ~pr_s9[31];
			pf_s10.zero        <= (dv9 == 32'sd0);
			pf_s10.dividend    <= pr_s9[31] ? pr_s9 : {pr_s9[30:0], 1'b0};
			pf_s10.divisor     <= $unsigned(dv9);
			hd2_s10            <= hd_s9 * h2;
			he_s10             <= he_s9;
		end
	end

	// Stage 11: humidity main product
	front_t pf_s11;
	logic signed [31:0] hc_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s11 <= pf_s10;
			hc_s11 <= he_s10 * sdiv_p2(hd2_s10 + 32'sd8192, 14);
		end
	end

	// Stage 12: square of the scaled product
	logic signed [31:0] hs11;
	front_t pf_s12;
	logic signed [31:0] hc_s12, hsq_s12;

	assign hs11 = sdiv_p2(hc_s11, 15);

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s12  <= pf_s11;
			hc_s12  <= hc_s11;
			hsq_s12 <= hs11 * hs11;
		end
	end

	// Stage 13: apply H1
	front_t pf_s13;
	logic signed [31:0] hc_s13, hdh_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s13  <= pf_s12;
			hc_s13  <= hc_s12;
			hdh_s13 <= sdiv_p2(hsq_s12, 7) * h1;
		end
	end

	// Stage 14: humidity clamp and result
	logic signed [31:0] he13, hcl;
	logic [31:0] hum13;
	front_t pf_s14;

	always_comb begin
		he13 = hc_s13 - sdiv_p2(hdh_s13, 4);
		if (he13 < 32'sd0) begin
			hcl = 32'sd0;
		end else if (he13 > HUM_CAP) begin
			hcl = HUM_CAP;
		end else begin
			hcl = he13;
		end
		hum13 = $unsigned(hcl) >> 12;
		if (hum13 > HUM_HI) begin
			hum13 = HUM_HI;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s14.temperature <= pf_s13.temperature;
			pf_s14.humidity    <= hum13[16:0];
			pf_s14.shifted     <= pf_s13.shifted;
			pf_s14.zero        <= pf_s13.zero;
			pf_s14.dividend    <= pf_s13.dividend;
			pf_s14.divisor     <= pf_s13.divisor;
		end
	end

	assign out_data = pf_s14;

endmodule

/* rtl/esc_div.sv */
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned 32 by 32 restoring divider, one quotient bit per
// stage, carrying the finished temperature and humidity alongside.
// ----------------------------------------------------------------------------
module esc_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  esc_pkg::front_t   in_data,
	output logic          out_valid,
	output esc_pkg::quot_t    out_data
);
	import esc_pkg::*;

	localparam int unsigned NBIT = 32;

	// Entry k holds the beat after stage k
	logic [NBIT-1:0]    vld_s;
	logic [31:0]        rem_s [0:NBIT-2];
	logic [31:0]        num_s [0:NBIT-2];
	logic [31:0]        den_s [0:NBIT-2];
	logic [31:0]        quo_s [0:NBIT-1];
	logic signed [14:0] temp_s [0:NBIT-1];
	logic [16:0]        hum_s [0:NBIT-1];
	logic [NBIT-1:0]    shf_s;
	logic [NBIT-1:0]    zero_s;

	for (genvar k = 0; k < NBIT; k++) begin : g_stage
		logic               vld_in, shf_in, zero_in;
		logic [31:0]        rem_in, num_in, quo_in, den_in;
		logic signed [14:0] temp_in;
		logic [16:0]        hum_in;
		logic [32:0]        trial;
		logic [32:0]        diff;
		logic               ge;

		// First stage takes the front end beat, the rest the stage before
		if (k == 0) begin : g_head
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign num_in  = in_data.dividend;
			assign quo_in  = '0;
			assign den_in  = in_data.divisor;
			assign temp_in = in_data.temperature;
			assign hum_in  = in_data.humidity;
			assign shf_in  = in_data.shifted;
			assign zero_in = in_data.zero;
		end else begin : g_link
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign num_in  = num_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign den_in  = den_s[k-1];
			assign temp_in = temp_s[k-1];
			assign hum_in  = hum_s[k-1];
			assign shf_in  = shf_s[k-1];
			assign zero_in = zero_s[k-1];
		end

		// Shift in the next dividend bit, try the subtract
		assign trial = {rem_in, num_in[31]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = ~diff[32];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= {quo_in[30:0], ge};
				temp_s[k] <= temp_in;
				hum_s[k]  <= hum_in;
				shf_s[k]  <= shf_in;
				zero_s[k] <= zero_in;
			end
		end

		// Carry remainder, dividend and divisor on to the next bit
		if (k < NBIT - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[31:0] : trial[31:0];
					num_s[k] <= {num_in[30:0], 1'b0};
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign out_valid            = vld_s[NBIT-1];
	assign out_data.temperature = temp_s[NBIT-1];
	assign out_data.humidity    = hum_s[NBIT-1];
	assign out_data.shifted     = shf_s[NBIT-1];
	assign out_data.zero        = zero_s[NBIT-1];
	assign out_data.quotient    = quo_s[NBIT-1];

endmodule

/* rtl/esc_back.sv */
// ----------------------------------------------------------------------------
// esc_back
// Three-stage pressure correction after the divide; the last stage is the
// output register of the block.
// ----------------------------------------------------------------------------
module esc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  esc_pkg::quot_t    in_data,
	input  esc_pkg::calib_t   calib,
	output logic          out_valid,
	output esc_pkg::out_beat_t out_beat
);
	import esc_pkg::*;

	logic signed [31:0] p7, p8, p9;

	assign p7 = {{16{calib.press_calib_b[47]}}, calib.press_calib_b[47:32]};
	assign p8 = {{16{calib.press_calib_b[63]}}, calib.press_calib_b[63:48]};
	assign p9 = {{16{calib.press_calib_c[15]}}, calib.press_calib_c};

	logic vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: undo the pre-shift, square and P8 products
	logic [31:0] pr0, pr8;
	logic signed [14:0] temp_s1, temp_s2;
	logic [16:0] hum_s1, hum_s2;
	logic zero_s1, zero_s2;
	logic [31:0] pr_s1, pr_s2, sq_s1;
	logic signed [31:0] d0_s1, cm_s2, dd_s2;

	assign pr0 = in_data.shifted ? in_data.quotient : {in_data.quotient[30:0], 1'b0};
	assign pr8 = {3'd0, pr0[31:3]};

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s1 <= in_data.temperature;
			hum_s1  <= in_data.humidity;
			zero_s1 <= in_data.zero;
			pr_s1   <= pr0;
			sq_s1   <= pr8 * pr8;
			d0_s1   <= $signed({2'd0, pr0[31:2]}) * p8;
		end
	end

	// Stage 2: apply P9, scale P8 term
	always_ff @(posedge clk) begin
		if (en) begin
			temp_s2 <= temp_s1;
			hum_s2  <= hum_s1;
			zero_s2 <= zero_s1;
			pr_s2   <= pr_s1;
			cm_s2   <= p9 * $signed({13'd0, sq_s1[31:13]});
			dd_s2   <= sdiv_p2(d0_s1, 13);
		end
	end

	// Stage 3: final sum and clamp
	logic [31:0] pfin, pcl;

	always_comb begin
		pfin = pr_s2 + $unsigned(sdiv_p2(sdiv_p2(cm_s2, 12) + dd_s2 + p7, 4));
		if (zero_s2) begin
			pcl = PRESS_LO;
		end else if (pfin < PRESS_LO) begin
			pcl = PRESS_LO;
		end else if (pfin > PRESS_HI) begin
			pcl = PRESS_HI;
		end else begin
			pcl = pfin;
		end
	end

	out_beat_t beat_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			beat_s3.temperature <= temp_s2;
			beat_s3.humidity    <= hum_s2;
			beat_s3.pressure    <= pcl[16:0];
		end
	end

	assign out_valid = vld_s3;
	assign out_beat  = beat_s3;

endmodule

/* rtl/environment_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// environment_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw sensor
// bursts, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one raw 8-byte burst per beat; out_valid/
//   out_ready carry the compensated temperature, pressure and humidity.
//   Calibration words are loaded through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the pipeline holds no beats, as the block
//   does not enforce it; the write takes effect at once.
//   A beat passes 14 front stages (fine temperature, humidity, divide
//   operands), 32 stages of the restoring divider (one quotient bit each)
//   and 3 pressure correction stages ending in the output register.
//   Throughput is one beat per cycle; every stage takes a new beat each
//   cycle while the output is free or being taken.
//   When out_ready is low with a beat waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module environment_sensor_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  esc_pkg::in_beat_t    in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output esc_pkg::out_beat_t   out_beat,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);
	import esc_pkg::*;

	calib_t calib_q;

	// Load calibration words; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP:    calib_q.temp_calib    <= cfg_data[47:0];
				CFG_PRESS_A: calib_q.press_calib_a <= cfg_data;
				CFG_PRESS_B: calib_q.press_calib_b <= cfg_data;
				CFG_PRESS_C: calib_q.press_calib_c <= cfg_data[15:0];
				CFG_HUM:     calib_q.hum_calib     <= cfg_data;
				default:     calib_q               <= calib_q;
			endcase
		end
	end

	// Advance every stage unless a result is held at the output
	logic en;
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	logic   front_vld, div_vld;
	front_t front_data;
	quot_t  div_data;

	esc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_beat  (in_beat),
		.calib    (calib_q),
		.out_valid(front_vld),
		.out_data (front_data)
	);

	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_vld),
		.in_data  (front_data),
		.out_valid(div_vld),
		.out_data (div_data)
	);

	esc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_vld),
		.in_data  (div_data),
		.calib    (calib_q),
		.out_valid(out_valid),
		.out_beat (out_beat)
	);

endmodule
